// File: src/lbbgk_pkg.sv
// Shared types, constants and the D3Q19 direction table for the BGK collision core.
package lbbgk_pkg;

  localparam int Q_FRAC   = 24;
  localparam int DATA_W   = 32;
  localparam int RELAX_W  = 26;
  localparam int DIR_W    = 5;
  localparam int NUM_DIRS = 19;

  localparam logic [DIR_W-1:0]   AXIS_LAST   = 5'd6;
  localparam logic [RELAX_W-1:0] RELAX_RESET = 26'd32263877;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  localparam logic signed [44:0] TWO_Q24  = 45'sd33554432;
  localparam logic signed [32:0] TWOB_MAX = 33'sd4294967295;
  localparam logic [63:0]        HALF_Q24 = 64'd8388608;

  localparam int DIV_W      = 36;
  localparam int DIV_STAGES = 3;
  localparam int DIV_STEPS  = 6;
  localparam int REM_W      = 4;
  localparam logic [5:0] DIV_SMALL = 6'd3;
  localparam logic [5:0] DIV_LARGE = 6'd9;

  typedef logic signed [1:0] comp_t;
  typedef comp_t [0:2] dvec_t;

  localparam comp_t C0 = 2'sd0;
  localparam comp_t CP = 2'sd1;
  localparam comp_t CM = -2'sd1;

  localparam dvec_t DIR_VEC [NUM_DIRS] = '{
    '{C0, C0, C0},
    '{CP, C0, C0}, '{CM, C0, C0}, '{C0, C0, CP}, '{C0, C0, CM},
    '{C0, CM, C0}, '{C0, CP, C0},
    '{CP, C0, CP}, '{CM, C0, CM}, '{CP, C0, CM}, '{CM, C0, CP},
    '{C0, CM, CP}, '{C0, CP, CM}, '{C0, CP, CP}, '{C0, CM, CM},
    '{CP, CM, C0}, '{CM, CP, C0}, '{CP, CP, C0}, '{CM, CM, C0}
  };

  typedef enum logic [1:0] {
    CLS_REST = 2'd0,
    CLS_AXIS = 2'd1,
    CLS_DIAG = 2'd2
  } dclass_t;

  typedef struct packed {
    logic                     valid;
    logic                     bypass;
    logic signed [DATA_W-1:0] pop;
  } side_t;

  typedef struct packed {
    side_t              side;
    dclass_t            cls;
    logic signed [63:0] prod;
  } prod_t;

  typedef struct packed {
    side_t            side;
    logic             neg;
    logic             ovf;
    logic [DIV_W-1:0] w;
  } quot_t;

endpackage

// File: src/lbbgk_feq.sv
// Equilibrium front end: direction lookup, squares, bracket and density product.
module lbbgk_feq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic signed [31:0]   density,
  input  logic signed [31:0]   vel_x,
  input  logic signed [31:0]   vel_y,
  input  logic signed [31:0]   vel_z,
  input  logic [4:0]           direction,
  input  logic signed [31:0]   population_in,
  output lbbgk_pkg::prod_t     prod_out
);

  function automatic logic signed [33:0] comp_term(lbbgk_pkg::comp_t c,
                                                   logic signed [31:0] v);
    logic signed [33:0] t;
    t = 34'(v);
    case (c)
      lbbgk_pkg::CP: return t;
      lbbgk_pkg::CM: return -t;
      default:       return '0;
    endcase
  endfunction

  logic                bypass_in;
  logic [4:0]          dir_idx;
  lbbgk_pkg::dvec_t    dv;
  logic signed [33:0]  cu_sum;
  logic signed [31:0]  cu_sat;
  lbbgk_pkg::dclass_t  cls_in;

  assign bypass_in = direction > 5'(lbbgk_pkg::NUM_DIRS - 1);
  assign dir_idx   = bypass_in ? '0 : direction;
  assign dv        = lbbgk_pkg::DIR_VEC[dir_idx];

  always_comb begin
    cu_sum = comp_term(dv[0], vel_x) + comp_term(dv[1], vel_y) + comp_term(dv[2], vel_z);
    if (cu_sum > 34'(lbbgk_pkg::SAT_MAX)) begin
      cu_sat = lbbgk_pkg::SAT_MAX;
    end else if (cu_sum < 34'(lbbgk_pkg::SAT_MIN)) begin
      cu_sat = lbbgk_pkg::SAT_MIN;
    end else begin
      cu_sat = cu_sum[31:0];
    end
    if (dir_idx == '0) begin
      cls_in = lbbgk_pkg::CLS_REST;
    end else if (dir_idx <= lbbgk_pkg::AXIS_LAST) begin
      cls_in = lbbgk_pkg::CLS_AXIS;
    end else begin
      cls_in = lbbgk_pkg::CLS_DIAG;
    end
  end

  // stage 1: velocity projection
  lbbgk_pkg::side_t    s1_side;
  lbbgk_pkg::dclass_t  s1_cls;
  logic signed [31:0]  s1_rho, s1_vx, s1_vy, s1_vz, s1_cu;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side <= '0;
    end else begin
      s1_side.valid  <= load;
      s1_side.bypass <= bypass_in;
      s1_side.pop    <= population_in;
    end
    s1_cls <= cls_in;
    s1_rho <= density;
    s1_vx  <= vel_x;
    s1_vy  <= vel_y;
    s1_vz  <= vel_z;
    s1_cu  <= cu_sat;
  end

  // stage 2: squares
  lbbgk_pkg::side_t    s2_side;
  lbbgk_pkg::dclass_t  s2_cls;
  logic signed [31:0]  s2_rho, s2_cu;
  logic signed [63:0]  s2_sqc, s2_sqx, s2_sqy, s2_sqz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side <= '0;
    end else begin
      s2_side <= s1_side;
    end
    s2_cls <= s1_cls;
    s2_rho <= s1_rho;
    s2_cu  <= s1_cu;
    s2_sqc <= s1_cu * s1_cu;
    s2_sqx <= s1_vx * s1_vx;
    s2_sqy <= s1_vy * s1_vy;
    s2_sqz <= s1_vz * s1_vz;
  end

  // stage 3: rounded squares
  logic [62:0] rc, rx, ry, rz;

  assign rc = s2_sqc[62:0] + 63'(lbbgk_pkg::HALF_Q24);
  assign rx = s2_sqx[62:0] + 63'(lbbgk_pkg::HALF_Q24);
  assign ry = s2_sqy[62:0] + 63'(lbbgk_pkg::HALF_Q24);
  assign rz = s2_sqz[62:0] + 63'(lbbgk_pkg::HALF_Q24);

  lbbgk_pkg::side_t    s3_side;
  lbbgk_pkg::dclass_t  s3_cls;
  logic signed [31:0]  s3_rho, s3_cu;
  logic [38:0]         s3_cu2;
  logic [40:0]         s3_usq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_side <= '0;
    end else begin
      s3_side <= s2_side;
    end
    s3_cls <= s2_cls;
    s3_rho <= s2_rho;
    s3_cu  <= s2_cu;
    s3_cu2 <= rc[62:24];
    s3_usq <= 41'(rx[62:24]) + 41'(ry[62:24]) + 41'(rz[62:24]);
  end

  // stage 4: twice the bracket, saturated
  logic signed [44:0] twob_full;
  logic signed [32:0] twob_sat;

  always_comb begin
    twob_full = lbbgk_pkg::TWO_Q24 + 45'sd6 * 45'(s3_cu)
              + 45'sd9 * $signed(45'(s3_cu2)) - 45'sd3 * $signed(45'(s3_usq));
    if (twob_full > 45'(lbbgk_pkg::TWOB_MAX)) begin
      twob_sat = lbbgk_pkg::TWOB_MAX;
    end else if (twob_full < -45'(lbbgk_pkg::TWOB_MAX)) begin
      twob_sat = -lbbgk_pkg::TWOB_MAX;
    end else begin
      twob_sat = twob_full[32:0];
    end
  end

  lbbgk_pkg::side_t    s4_side;
  lbbgk_pkg::dclass_t  s4_cls;
  logic signed [31:0]  s4_rho;
  logic signed [32:0]  s4_twob;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_side <= '0;
    end else begin
      s4_side <= s3_side;
    end
    s4_cls  <= s3_cls;
    s4_rho  <= s3_rho;
    s4_twob <= twob_sat;
  end

  // stage 5: density times bracket
  logic signed [64:0] prod_full;

  assign prod_full = s4_rho * s4_twob;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_out.side <= '0;
    end else begin
      prod_out.side <= s4_side;
    end
    prod_out.cls  <= s4_cls;
    prod_out.prod <= prod_full[63:0];
  end

endmodule

// File: src/lbbgk_div.sv
// Pipelined rounding divider by the lattice weight denominator, radix 4 per step.
module lbbgk_div (
  input  logic              clk,
  input  logic              rst,
  input  lbbgk_pkg::prod_t  prod_in,
  output lbbgk_pkg::quot_t  quot_out
);

  typedef struct packed {
    logic                          nine;
    logic [lbbgk_pkg::REM_W-1:0]   r;
    lbbgk_pkg::quot_t              q;
  } stage_t;

  function automatic stage_t div_stage(stage_t s);
    stage_t     o;
    logic [5:0] v, d1, d2, d3;
    logic [1:0] qd;
    o  = s;
    d1 = s.nine ? lbbgk_pkg::DIV_LARGE : lbbgk_pkg::DIV_SMALL;
    d2 = d1 + d1;
    d3 = d2 + d1;
    for (int j = 0; j < lbbgk_pkg::DIV_STEPS; j++) begin
      v = {o.r, o.q.w[lbbgk_pkg::DIV_W-1 -: 2]};
      if (v >= d3) begin
        qd = 2'd3;
        v  = v - d3;
      end else if (v >= d2) begin
        qd = 2'd2;
        v  = v - d2;
      end else if (v >= d1) begin
        qd = 2'd1;
        v  = v - d1;
      end else begin
        qd = 2'd0;
      end
      o.r   = v[lbbgk_pkg::REM_W-1:0];
      o.q.w = {o.q.w[lbbgk_pkg::DIV_W-3:0], qd};
    end
    return o;
  endfunction

  logic [63:0] mag, bias, biased;
  logic [39:0] n_c, m_c;
  stage_t      st0_c;

  always_comb begin
    mag = prod_in.prod[63] ? unsigned'(-prod_in.prod) : unsigned'(prod_in.prod);
    case (prod_in.cls)
      lbbgk_pkg::CLS_REST: bias = 64'd6 << (lbbgk_pkg::Q_FRAC - 1);
      lbbgk_pkg::CLS_AXIS: bias = 64'd36 << (lbbgk_pkg::Q_FRAC - 1);
      default:             bias = 64'd72 << (lbbgk_pkg::Q_FRAC - 1);
    endcase
    biased = mag + bias;
    n_c    = biased[63:24];
    case (prod_in.cls)
      lbbgk_pkg::CLS_REST: m_c = n_c >> 1;
      lbbgk_pkg::CLS_AXIS: m_c = n_c >> 2;
      default:             m_c = n_c >> 3;
    endcase
    st0_c.nine   = prod_in.cls != lbbgk_pkg::CLS_REST;
    st0_c.r      = '0;
    st0_c.q.side = prod_in.side;
    st0_c.q.neg  = prod_in.prod[63];
    st0_c.q.ovf  = |m_c[39:35];
    st0_c.q.w    = {1'b0, m_c[34:0]};
  end

  stage_t st      [lbbgk_pkg::DIV_STAGES+1];
  stage_t st_next [lbbgk_pkg::DIV_STAGES+1];

  always_comb begin
    st_next[0] = st0_c;
    for (int k = 1; k <= lbbgk_pkg::DIV_STAGES; k++) begin
      st_next[k] = div_stage(st[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= lbbgk_pkg::DIV_STAGES; k++) begin
        st[k] <= '0;
      end
    end else begin
      for (int k = 0; k <= lbbgk_pkg::DIV_STAGES; k++) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign quot_out = st[lbbgk_pkg::DIV_STAGES].q;

endmodule

// File: src/lbbgk_relax.sv
// Relaxation back end: equilibrium saturation, rate product, rounding and output register.
module lbbgk_relax (
  input  logic                clk,
  input  logic                rst,
  input  lbbgk_pkg::quot_t    quot_in,
  input  logic [25:0]         rate,
  output logic                done,
  output logic signed [31:0]  population_out
);

  logic               sat_pos, sat_neg;
  logic signed [31:0] feq;
  logic signed [32:0] diff_c;

  always_comb begin
    sat_pos = quot_in.ovf | (|quot_in.w[35:31]);
    sat_neg = quot_in.ovf | (|quot_in.w[35:32]) | (quot_in.w[31] & (|quot_in.w[30:0]));
    if (!quot_in.neg) begin
      feq = sat_pos ? lbbgk_pkg::SAT_MAX : signed'(quot_in.w[31:0]);
    end else begin
      feq = sat_neg ? lbbgk_pkg::SAT_MIN : -signed'(quot_in.w[31:0]);
    end
    diff_c = 33'(feq) - 33'(quot_in.side.pop);
  end

  // distance to equilibrium
  lbbgk_pkg::side_t   r1_side;
  logic signed [32:0] r1_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_side <= '0;
    end else begin
      r1_side <= quot_in.side;
    end
    r1_diff <= diff_c;
  end

  // rate product
  lbbgk_pkg::side_t   r2_side;
  logic signed [59:0] r2_mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_side <= '0;
    end else begin
      r2_side <= r1_side;
    end
    r2_mul <= $signed({1'b0, rate}) * r1_diff;
  end

  // add population back
  lbbgk_pkg::side_t   r3_side;
  logic signed [63:0] r3_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_side <= '0;
    end else begin
      r3_side <= r2_side;
    end
    r3_total <= (64'(r2_side.pop) <<< lbbgk_pkg::Q_FRAC) + 64'(r2_mul);
  end

  // round, saturate or bypass, drive result
  logic [63:0]        rnd;
  logic signed [39:0] res40;
  logic signed [31:0] res;

  always_comb begin
    rnd   = r3_total + lbbgk_pkg::HALF_Q24 - 64'(r3_total[63]);
    res40 = signed'(rnd[63:24]);
    if (r3_side.bypass) begin
      res = r3_side.pop;
    end else if (res40 > 40'(lbbgk_pkg::SAT_MAX)) begin
      res = lbbgk_pkg::SAT_MAX;
    end else if (res40 < 40'(lbbgk_pkg::SAT_MIN)) begin
      res = lbbgk_pkg::SAT_MIN;
    end else begin
      res = res40[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r3_side.valid;
    end
    population_out <= res;
  end

endmodule

// File: src/lattice_boltzmann_bgk_collision_core.sv
// Top level of the D3Q19 BGK collision core: relax-rate register and pipeline.
//
// Usage: drive density, vel_x, vel_y, vel_z, direction and population_in
// and raise start; an item is taken at every rising edge with start high
// and busy low. busy stays low, so one item can enter every cycle.
// Each item gives one population_out, shown for exactly one cycle with
// done high once it has passed the whole pipeline; items
// leave in the order they entered. Throughput is one item per clock,
// set by the 13-stage pipeline (five equilibrium stages, four divider
// stages, four relaxation stages). The result side has no back pressure:
// done must be taken when it appears.
// relax_rate is written when relax_rate_valid is high; relax_rate_ready
// is always high. Write it only with no items in flight.
// Reset clears all pipeline valid bits (no done pulses follow) and loads
// the relax rate with its default, 1/0.52 in Q2.24.
// Direction codes 19 to 31 return population_in unchanged.
module lattice_boltzmann_bgk_collision_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  density,
  input  logic signed [31:0]  vel_x,
  input  logic signed [31:0]  vel_y,
  input  logic signed [31:0]  vel_z,
  input  logic [4:0]          direction,
  input  logic signed [31:0]  population_in,
  output logic                done,
  output logic signed [31:0]  population_out,
  input  logic                relax_rate_valid,
  output logic                relax_rate_ready,
  input  logic [25:0]         relax_rate
);

  logic [25:0]       rate;
  lbbgk_pkg::prod_t  prod;
  lbbgk_pkg::quot_t  quot;

  assign busy             = 1'b0;
  assign relax_rate_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= lbbgk_pkg::RELAX_RESET;
    end else if (relax_rate_valid && relax_rate_ready) begin
      rate <= relax_rate;
    end
  end

  lbbgk_feq u_feq (
    .clk           (clk),
    .rst           (rst),
    .load          (start && !busy),
    .density       (density),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .vel_z         (vel_z),
    .direction     (direction),
    .population_in (population_in),
    .prod_out      (prod)
  );

  lbbgk_div u_div (
    .clk      (clk),
    .rst      (rst),
    .prod_in  (prod),
    .quot_out (quot)
  );

  lbbgk_relax u_relax (
    .clk            (clk),
    .rst            (rst),
    .quot_in        (quot),
    .rate           (rate),
    .done           (done),
    .population_out (population_out)
  );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the D3Q19 BGK collision core with a scoreboard class.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int ITEMS_PER_RATE = 150;
  localparam logic signed [31:0] ONE_Q = 32'sd16777216;

  class population_board;
    longint rate;
    logic signed [lbbgk_pkg::DATA_W-1:0] expected_pop[$];
    int errors;
    int checked;

    function new();
      rate = longint'(lbbgk_pkg::RELAX_RESET);
      errors = 0;
      checked = 0;
    endfunction

    function void set_rate(logic [lbbgk_pkg::RELAX_W-1:0] value);
      rate = longint'(value);
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function longint div_round(longint num, longint den);
      longint mag, q, r;
      mag = (num < 0) ? -num : num;
      q = mag / den;
      r = mag % den;
      if (r >= den - r) q++;
      return (num < 0) ? -q : q;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void add_node(logic signed [lbbgk_pkg::DATA_W-1:0] rho_in,
                           logic signed [lbbgk_pkg::DATA_W-1:0] ux,
                           logic signed [lbbgk_pkg::DATA_W-1:0] uy,
                           logic signed [lbbgk_pkg::DATA_W-1:0] uz,
                           logic [lbbgk_pkg::DIR_W-1:0] dir,
                           logic signed [lbbgk_pkg::DATA_W-1:0] pop);
      longint one, rho, vx, vy, vz, f, cu, cu2, usq, twob, lim, den, feq, total;
      longint smin, smax;
      lbbgk_pkg::dclass_t cls;
      one = longint'(1) << lbbgk_pkg::Q_FRAC;
      rho = longint'(rho_in);
      vx = longint'(ux);
      vy = longint'(uy);
      vz = longint'(uz);
      f = longint'(pop);
      lim = longint'(lbbgk_pkg::TWOB_MAX);
      smin = longint'(lbbgk_pkg::SAT_MIN);
      smax = longint'(lbbgk_pkg::SAT_MAX);
      if (dir >= lbbgk_pkg::NUM_DIRS) begin
        expected_pop.push_back(pop);
        return;
      end
      cu = longint'(lbbgk_pkg::DIR_VEC[dir][0]) * vx + longint'(lbbgk_pkg::DIR_VEC[dir][1]) * vy
         + longint'(lbbgk_pkg::DIR_VEC[dir][2]) * vz;
      cu = clamp(cu, smin, smax);
      cu2 = div_round(cu * cu, one);
      usq = div_round(vx * vx, one) + div_round(vy * vy, one) + div_round(vz * vz, one);
      twob = clamp(2 * one + 6 * cu + 9 * cu2 - 3 * usq, -lim, lim);
      if (dir == 0) cls = lbbgk_pkg::CLS_REST;
      else if (dir <= lbbgk_pkg::AXIS_LAST) cls = lbbgk_pkg::CLS_AXIS;
      else cls = lbbgk_pkg::CLS_DIAG;
      case (cls)
        lbbgk_pkg::CLS_REST: den = 6;
        lbbgk_pkg::CLS_AXIS: den = 36;
        default:             den = 72;
      endcase
      feq = clamp(div_round(rho * twob, den * one), smin, smax);
      total = f * one + rate * (feq - f);
      expected_pop.push_back(32'(clamp(div_round(total, one), smin, smax)));
    endfunction

    function void check_pop(logic signed [lbbgk_pkg::DATA_W-1:0] got);
      logic signed [lbbgk_pkg::DATA_W-1:0] want;
      checked++;
      if (expected_pop.size() == 0) begin
        flag($sformatf("population_out %0d with no item pending", got));
        return;
      end
      want = expected_pop.pop_front();
      if (got !== want)
        flag($sformatf("population_out mismatch: expected %0d got %0d", want, got));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [31:0] density;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic [4:0] direction;
  logic signed [31:0] population_in;
  logic done;
  logic signed [31:0] population_out;
  logic relax_rate_valid;
  logic relax_rate_ready;
  logic [25:0] relax_rate;

  population_board sb = new();
  int idle_pct;
  int items_sent;
  int rate_writes;
  int quiet_cycles;
  logic [25:0] rate_list [12];

  lattice_boltzmann_bgk_collision_core i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .density(density),
    .vel_x(vel_x),
    .vel_y(vel_y),
    .vel_z(vel_z),
    .direction(direction),
    .population_in(population_in),
    .done(done),
    .population_out(population_out),
    .relax_rate_valid(relax_rate_valid),
    .relax_rate_ready(relax_rate_ready),
    .relax_rate(relax_rate)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_pop(population_out);
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (relax_rate_valid && relax_rate_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL lattice_boltzmann_bgk_collision_core");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_word(input int center, input int spread);
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return center + int'($urandom_range(2 * spread)) - spread;
    if (sel < 85) return $urandom;
    case ($urandom_range(4))
      0: return lbbgk_pkg::SAT_MAX;
      1: return lbbgk_pkg::SAT_MIN;
      2: return 32'd0;
      3: return 32'hFFFF_FFFF;
      default: return 32'd1;
    endcase
  endfunction

  task automatic send_item(input logic signed [31:0] rho, input logic signed [31:0] ux,
                           input logic signed [31:0] uy, input logic signed [31:0] uz,
                           input logic [4:0] dir, input logic signed [31:0] pop);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    density <= rho;
    vel_x <= ux;
    vel_y <= uy;
    vel_z <= uz;
    direction <= dir;
    population_in <= pop;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.add_node(rho, ux, uy, uz, dir, pop);
    items_sent++;
  endtask

  task automatic send_random();
    logic [4:0] dir;
    dir = ($urandom_range(99) < 90) ? 5'($urandom_range(18)) : 5'($urandom_range(31, 19));
    send_item(pick_word(ONE_Q, 1 << 22), pick_word(0, 1 << 22), pick_word(0, 1 << 22),
              pick_word(0, 1 << 22), dir, pick_word(1 << 22, 1 << 22));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_pop.size() != 0) @(posedge clk);
  endtask

  task automatic write_rate(input logic [25:0] value);
    @(negedge clk);
    relax_rate_valid <= 1'b1;
    relax_rate <= value;
    @(posedge clk);
    while (!relax_rate_ready) @(posedge clk);
    sb.set_rate(value);
    rate_writes++;
    @(negedge clk);
    relax_rate_valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    density = '0;
    vel_x = '0;
    vel_y = '0;
    vel_z = '0;
    direction = '0;
    population_in = '0;
    relax_rate_valid = 1'b0;
    relax_rate = '0;
    idle_pct = 15;
    items_sent = 0;
    rate_writes = 0;
    quiet_cycles = 0;
    rate_list[0] = 26'd0;
    rate_list[1] = 26'd33554432;
    rate_list[2] = 26'h3FF_FFFF;
    rate_list[3] = lbbgk_pkg::RELAX_RESET;
    rate_list[4] = 26'd16777216;
    rate_list[5] = 26'd1;
    for (int k = 6; k < 12; k++) rate_list[k] = 26'($urandom_range(33554432));
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int d = 0; d < lbbgk_pkg::NUM_DIRS; d++)
      send_item(ONE_Q + 32'sd40000 * d, 32'sd838861, -32'sd503316, 32'sd335544, 5'(d),
                32'sd932068 + 32'sd1000 * d);
    send_item(ONE_Q, 32'sd1000, 32'sd2000, 32'sd3000, 5'd19, lbbgk_pkg::SAT_MAX);
    send_item(ONE_Q, 32'sd1000, 32'sd2000, 32'sd3000, 5'd31, lbbgk_pkg::SAT_MIN);
    send_item(lbbgk_pkg::SAT_MAX, lbbgk_pkg::SAT_MAX, lbbgk_pkg::SAT_MAX, lbbgk_pkg::SAT_MAX,
              5'd7, lbbgk_pkg::SAT_MAX);
    send_item(lbbgk_pkg::SAT_MIN, lbbgk_pkg::SAT_MIN, lbbgk_pkg::SAT_MIN, lbbgk_pkg::SAT_MIN,
              5'd0, lbbgk_pkg::SAT_MIN);
    send_item(lbbgk_pkg::SAT_MAX, lbbgk_pkg::SAT_MIN, lbbgk_pkg::SAT_MAX, lbbgk_pkg::SAT_MIN,
              5'd17, lbbgk_pkg::SAT_MIN);
    send_item(32'sd0, 32'sd0, 32'sd0, 32'sd0, 5'd0, 32'sd0);
    drain();

    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 15 : (p == 1) ? 62 : 0;
      for (int s = 0; s < 4; s++) begin
        write_rate(rate_list[p * 4 + s]);
        for (int i = 0; i < ITEMS_PER_RATE; i++) begin
          send_random();
          if (i == ITEMS_PER_RATE / 2) drain();
        end
        drain();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.expected_pop.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.expected_pop.size()));
    $display("covered %0d items (all 19 directions, bypass codes, saturating extremes)",
             items_sent);
    $display("over %0d relax-rate writes; %0d results checked, %0d errors",
             rate_writes, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS lattice_boltzmann_bgk_collision_core");
    end else begin
      $display("FAIL lattice_boltzmann_bgk_collision_core");
    end
    $finish;
  end

endmodule
